// ----- rtl/ims_pkg.sv -----
// Shared constants, types and state codes for the Ising spin update block.
package ims_pkg;

  // Lattice geometry: the side is a power of two so row and column are bit fields.
  localparam int ROW_W  = 5;
  localparam int SIDE   = 1 << ROW_W;
  localparam int IDX_W  = 2 * ROW_W;
  localparam int SITE_W = 10;
  localparam int KEEP_W = (IDX_W < SITE_W) ? IDX_W : SITE_W;

  // Payload and register widths.
  localparam int CMD_W     = 2;
  localparam int RAND_W    = 31;
  localparam int THR_W     = 32;
  localparam int REG_W     = 64;
  localparam int NREGS     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int SEL_W     = 3;
  localparam int MAG_W     = 12;
  localparam int BOND_W    = 13;

  localparam logic [REG_W-1:0] THR_RESET = 64'h8000_0000_8000_0000;

  // Command codes; the fourth code has no meaning and changes nothing.
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_DN,
    ST_MID,
    ST_CAP,
    ST_MPRE,
    ST_MPCAP,
    ST_MRD,
    ST_MCAP,
    ST_MCOL,
    ST_FIN
  } ims_state_t;

  // Threshold lookup request from the sequencer to the register file.
  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic             spin;
  } thr_req_t;

endpackage

// ----- rtl/ims_in_if.sv -----
// Input request channel: command, site, random fraction and load value.
interface ims_in_if import ims_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SITE_W-1:0] site;
  logic [RAND_W-1:0] rand_fraction;
  logic              load_value;

  modport source (output valid, cmd, site, rand_fraction, load_value, input ready);
  modport sink (input valid, cmd, site, rand_fraction, load_value, output ready);
endinterface

// ----- rtl/ims_out_if.sv -----
// Result channel: flip flag, spin after the operation and lattice measures.
interface ims_out_if import ims_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     flipped;
  logic                     spin_after;
  logic signed [MAG_W-1:0]  magnetization;
  logic signed [BOND_W-1:0] bond_sum;

  modport source (output valid, flipped, spin_after, magnetization, bond_sum, input ready);
  modport sink (input valid, flipped, spin_after, magnetization, bond_sum, output ready);
endinterface

// ----- rtl/ims_cfg_if.sv -----
// Configuration write channel: register index and 64-bit write data.
interface ims_cfg_if import ims_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/ims_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ims_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ims_thr_regs.sv -----
// Threshold register file with its configuration write port and lookup.
module ims_thr_regs import ims_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  ims_cfg_if.sink          cfg_ch,
  input  thr_req_t         req,
  output logic [THR_W-1:0] thr
);

  logic [REG_W-1:0] thr_r [NREGS];
  logic [REG_W-1:0] reg_sel;

  assign cfg_ch.ready = 1'b1;

  // Register writes; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREGS; i++) begin
        thr_r[i] <= THR_RESET;
      end
    end else if (cfg_ch.valid && (cfg_ch.index < CFG_IDX_W'(NREGS))) begin
      thr_r[cfg_ch.index] <= cfg_ch.data;
    end
  end

  // Pick the register by alignment, then the half by spin sign.
  always_comb begin
    if (req.sel < SEL_W'(NREGS)) begin
      reg_sel = thr_r[req.sel];
    end else begin
      reg_sel = '0;
    end
    thr = req.spin ? reg_sel[REG_W-1:THR_W] : reg_sel[THR_W-1:0];
  end

endmodule

// ----- rtl/ims_core.sv -----
// Sequencer and shared datapath: neighbor reads, acceptance test and lattice walk.
module ims_core import ims_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  ims_in_if.sink           in_ch,
  ims_out_if.source        out_ch,
  output thr_req_t         thr_req,
  input  logic [THR_W-1:0] thr,
  output logic             ram_we,
  output logic [ROW_W-1:0] ram_waddr,
  output logic [SIDE-1:0]  ram_wdata,
  output logic [ROW_W-1:0] ram_raddr,
  input  logic [SIDE-1:0]  ram_rdata
);

  ims_state_t state_r, state_nxt;

  logic [CMD_W-1:0]  cmd_r;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  col_r;
  logic [RAND_W-1:0] rand_r;
  logic              ld_r;
  logic              up_bit_r;
  logic              dn_bit_r;
  logic              spin_r;
  logic [SIDE-1:0]   cur_row_r;
  logic [SIDE-1:0]   prev_row_r;
  logic [ROW_W-1:0]  mrow_r;
  logic [ROW_W-1:0]  mcol_r;
  logic [MAG_W-1:0]  mag_r;
  logic [BOND_W-1:0] bond_r;
  logic              rd_vld_r;
  logic [SIDE-1:0]   row_vld_r;

  logic              out_vld_r;
  logic              out_flip_r;
  logic              out_spin_r;
  logic [MAG_W-1:0]  out_mag_r;
  logic [BOND_W-1:0] out_bond_r;

  logic              accept;
  logic              slot_free;
  logic              out_load;
  logic [IDX_W-1:0]  site_idx;
  logic [SIDE-1:0]   rword;
  logic              rbit_col;
  logic [ROW_W-1:0]  col_l;
  logic [ROW_W-1:0]  col_rt;
  logic [3:0]        nb_eq;
  logic              flip;
  logic              new_spin;
  logic [SIDE-1:0]   col_mask;
  logic [SIDE-1:0]   new_row;
  logic              ms;
  logic              ml;
  logic              mu;
  logic [MAG_W-1:0]  mag_d;
  logic [BOND_W-1:0] bond_d;

  // Handshake and site decode.
  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_vld_r || out_ch.ready;
  assign site_idx  = IDX_W'(in_ch.site[KEEP_W-1:0]);

  // Rows never written read as all spins down.
  assign rword    = rd_vld_r ? ram_rdata : '0;
  assign rbit_col = rword[col_r];

  // Acceptance test: the selector counts neighbors aligned with the spin.
  assign col_l  = col_r - ROW_W'(1);
  assign col_rt = col_r + ROW_W'(1);
  assign nb_eq  = ~({cur_row_r[col_l], cur_row_r[col_rt], up_bit_r, dn_bit_r} ^ {4{spin_r}});
  assign thr_req.sel  = SEL_W'(nb_eq[0]) + SEL_W'(nb_eq[1]) + SEL_W'(nb_eq[2])
                      + SEL_W'(nb_eq[3]);
  assign thr_req.spin = spin_r;
  assign flip = (cmd_r == CMD_UPDATE) && ({1'b0, rand_r} < thr);

  // New spin and the row word written back.
  always_comb begin
    case (cmd_r)
      CMD_UPDATE: new_spin = spin_r ^ flip;
      CMD_LOAD:   new_spin = ld_r;
      default:    new_spin = spin_r;
    endcase
  end
  assign col_mask = SIDE'(1) << col_r;
  assign new_row  = (cur_row_r & ~col_mask) | (new_spin ? col_mask : '0);

  // Lattice walk terms: spin, left neighbor and up neighbor at the walk column.
  assign ms     = cur_row_r[mcol_r];
  assign ml     = cur_row_r[mcol_r - ROW_W'(1)];
  assign mu     = prev_row_r[mcol_r];
  assign mag_d  = ms ? MAG_W'(1) : {MAG_W{1'b1}};
  always_comb begin
    case ({ms == ml, ms == mu})
      2'b11:   bond_d = BOND_W'(2);
      2'b00:   bond_d = ~BOND_W'(1);
      default: bond_d = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.cmd == CMD_UPDATE) ? ST_UP : ST_MID;
        end
      end
      ST_UP:    state_nxt = ST_DN;
      ST_DN:    state_nxt = ST_MID;
      ST_MID:   state_nxt = ST_CAP;
      ST_CAP:   state_nxt = (cmd_r == CMD_MEASURE) ? ST_MPRE : ST_FIN;
      ST_MPRE:  state_nxt = ST_MPCAP;
      ST_MPCAP: state_nxt = ST_MRD;
      ST_MRD:   state_nxt = ST_MCAP;
      ST_MCAP:  state_nxt = ST_MCOL;
      ST_MCOL: begin
        if (mcol_r == ROW_W'(SIDE - 1)) begin
          state_nxt = (mrow_r == ROW_W'(SIDE - 1)) ? ST_FIN : ST_MRD;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs: read address, write enable and result load.
  always_comb begin
    in_ch.ready = 1'b0;
    ram_raddr   = row_r;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_UP:   ram_raddr = row_r - ROW_W'(1);
      ST_DN:   ram_raddr = row_r + ROW_W'(1);
      ST_MPRE: ram_raddr = ROW_W'(SIDE - 1);
      ST_MRD:  ram_raddr = mrow_r;
      ST_FIN:  out_load = slot_free;
      default: ram_raddr = row_r;
    endcase
  end
  assign ram_we    = out_load && ((cmd_r == CMD_LOAD) || flip);
  assign ram_waddr = row_r;
  assign ram_wdata = new_row;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= row_vld_r[ram_raddr];
      if (ram_we) begin
        row_vld_r[row_r] <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Datapath registers stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_r  <= in_ch.cmd;
          row_r  <= site_idx[IDX_W-1:ROW_W];
          col_r  <= site_idx[ROW_W-1:0];
          rand_r <= in_ch.rand_fraction;
          ld_r   <= in_ch.load_value;
        end
      end
      ST_DN:  up_bit_r <= rbit_col;
      ST_MID: dn_bit_r <= rbit_col;
      ST_CAP: begin
        cur_row_r <= rword;
        spin_r    <= rbit_col;
      end
      ST_MPRE: begin
        mag_r  <= '0;
        bond_r <= '0;
        mrow_r <= '0;
      end
      ST_MPCAP: prev_row_r <= rword;
      ST_MCAP: begin
        cur_row_r <= rword;
        mcol_r    <= '0;
      end
      ST_MCOL: begin
        mag_r  <= mag_r + mag_d;
        bond_r <= bond_r + bond_d;
        mcol_r <= mcol_r + ROW_W'(1);
        if (mcol_r == ROW_W'(SIDE - 1)) begin
          prev_row_r <= cur_row_r;
          mrow_r     <= mrow_r + ROW_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_flip_r <= flip;
      out_spin_r <= new_spin;
      out_mag_r  <= (cmd_r == CMD_MEASURE) ? mag_r : '0;
      out_bond_r <= (cmd_r == CMD_MEASURE) ? bond_r : '0;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.flipped       = out_flip_r;
  assign out_ch.spin_after    = out_spin_r;
  assign out_ch.magnetization = out_mag_r;
  assign out_ch.bond_sum      = out_bond_r;

endmodule

// ----- rtl/ising_metropolis_spin_update_top.sv -----
// Update reads the rows above and below the site, then the site's row; other commands
// read only the site's row; measure then walks every row at one site per cycle.
// A new request is taken only after the last result is loaded into the output register.
// A finished result waits in the output register while the next request is taken.
// Synchronous active-low reset: all spins read as -1, thresholds return to always-accept.
module ising_metropolis_spin_update_top import ims_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ims_in_if.sink    in_ch,
  ims_out_if.source out_ch,
  ims_cfg_if.sink   cfg_ch
);

  thr_req_t         thr_req;
  logic [THR_W-1:0] thr;
  logic             ram_we;
  logic [ROW_W-1:0] ram_waddr;
  logic [SIDE-1:0]  ram_wdata;
  logic [ROW_W-1:0] ram_raddr;
  logic [SIDE-1:0]  ram_rdata;

  // Threshold registers.
  ims_thr_regs u_thr_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .req    (thr_req),
    .thr    (thr)
  );

  // Spin lattice, one row per word.
  ims_ram #(
    .WIDTH (SIDE),
    .DEPTH (SIDE)
  ) u_spin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and datapath.
  ims_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .thr_req   (thr_req),
    .thr       (thr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule
